// File: src/jts_pkg.sv
// jts_pkg: shared types, constants and table functions for the json token scanner
// used by json_token_scanner_top; no dependencies
`default_nettype none

package jts_pkg;

  // counter widths, fixed by the token field widths
  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 20;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

  // token kinds
  localparam logic [3:0] KIND_LBRACE   = 4'd0;
  localparam logic [3:0] KIND_RBRACE   = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_COLON    = 4'd4;
  localparam logic [3:0] KIND_COMMA    = 4'd5;
  localparam logic [3:0] KIND_STRING   = 4'd6;
  localparam logic [3:0] KIND_NUMBER   = 4'd7;
  localparam logic [3:0] KIND_TRUE     = 4'd8;
  localparam logic [3:0] KIND_END      = 4'd11;
  localparam logic [3:0] KIND_ERROR    = 4'd12;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_CTRL     = 3'd1;
  localparam logic [2:0] ERR_UNTERM   = 3'd2;
  localparam logic [2:0] ERR_NUMBER   = 3'd3;
  localparam logic [2:0] ERR_FRAC     = 3'd4;
  localparam logic [2:0] ERR_EXP      = 3'd5;
  localparam logic [2:0] ERR_KEYWORD  = 3'd6;
  localparam logic [2:0] ERR_UNEXPECT = 3'd7;

  // source characters
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_0        = 8'h30;
  localparam logic [7:0] CH_9        = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_UPPER_E  = 8'h45;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_A        = 8'h61;
  localparam logic [7:0] CH_E        = 8'h65;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_N        = 8'h6E;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_Z        = 8'h7A;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_CASE_BIT = 8'h20;

  // keyword selectors
  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  localparam int TDATA_W = 96;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_STR      = 4'd1,
    ST_STR_ESC  = 4'd2,
    ST_NEG      = 4'd3,
    ST_ZERO     = 4'd4,
    ST_INT      = 4'd5,
    ST_DOT      = 4'd6,
    ST_FRAC     = 4'd7,
    ST_EXP      = 4'd8,
    ST_EXP_SIGN = 4'd9,
    ST_EXP_DIG  = 4'd10,
    ST_KW       = 4'd11,
    ST_ERROR    = 4'd12
  } scan_state_t;

  typedef struct packed {
    logic [3:0]             kind;
    logic [OFFSET_BITS-1:0] offset;
    logic [OFFSET_BITS-1:0] length;
    logic [LINE_BITS-1:0]   line;
    logic [LINE_BITS-1:0]   column;
    logic [2:0]             err;
    logic                   last;
  } token_t;

  function automatic token_t build_token(input logic [3:0] kind,
                                         input logic [OFFSET_BITS-1:0] offset,
                                         input logic [OFFSET_BITS-1:0] length,
                                         input logic [LINE_BITS-1:0] line,
                                         input logic [LINE_BITS-1:0] column,
                                         input logic [2:0] err);
    token_t t;
    t.kind   = kind;
    t.offset = offset;
    t.length = length;
    t.line   = line;
    t.column = column;
    t.err    = err;
    t.last   = 1'b0;
    return t;
  endfunction

  // keyword text by selector and position
  function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] idx);
    logic [39:0] text;
    unique case (sel)
      KW_FALSE: text = "eslaf";
      KW_NULL:  text = {8'h00, "llun"};
      default:  text = {8'h00, "eurt"};
    endcase
    case (idx)
      3'd0:    kw_char = text[7:0];
      3'd1:    kw_char = text[15:8];
      3'd2:    kw_char = text[23:16];
      3'd3:    kw_char = text[31:24];
      3'd4:    kw_char = text[39:32];
      default: kw_char = CH_NUL;
    endcase
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] sel);
    unique case (sel)
      KW_FALSE: kw_len = 3'd5;
      default:  kw_len = 3'd4;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: src/json_token_scanner_top.sv
// json_token_scanner_top: byte-serial json tokenizer with a four-entry result queue
// depends on jts_pkg (types, character and code constants, keyword table)
// flow: a taken byte is held in the input register, then scanned into the result queue, whose
//   head drives m_tvalid; scanning waits while the queue holds more than two tokens
// throughput: one byte per cycle while the queue holds at most two tokens; a byte that closes
//   a number or keyword can also yield a second token
// reset: rst clears the scan state, counters and the result queue; no clearing pass
`default_nettype none

module json_token_scanner_top
  import jts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // input byte stream
  input  wire logic               s_tvalid,
  output      logic               s_tready,
  input  wire logic [7:0]         s_tdata,   // [7:0] data_byte
  input  wire logic               s_tlast,   // end_of_input
  // token stream
  output      logic               m_tvalid,
  input  wire logic               m_tready,
  output      logic [TDATA_W-1:0] m_tdata,   // start_offset, token_length, token_line,
                                             // token_column, error_code, zero pad
  output      logic [3:0]         m_tuser,   // token_kind
  output      logic               m_tlast    // last_of_run
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eoi;
  logic       proc;

  // scan state
  scan_state_t            scan_state, scan_state_next;
  logic [1:0]             kw_sel, kw_sel_next;
  logic [2:0]             kw_idx, kw_idx_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [LINE_BITS-1:0]   column_count, column_count_next;
  logic [OFFSET_BITS-1:0] start_offset_hold, start_offset_hold_next;
  logic [LINE_BITS-1:0]   start_line_hold, start_line_hold_next;
  logic [LINE_BITS-1:0]   start_column_hold, start_column_hold_next;

  // tokens produced by the current byte
  token_t     tok0, tok1;
  logic [1:0] push_n;

  // result queue
  token_t     fifo [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fifo_count;
  logic       pop;

  // queue always has room for two tokens when at most two are held
  assign proc     = in_valid && (fifo_count <= 3'd2);
  assign s_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eoi  <= s_tlast;
    end
  end

  // scan step: main state, then rescan of the closing byte, then end of document
  always_comb begin
    logic                   eoi;
    logic [7:0]             c;
    logic                   is_dig;
    logic                   is_alpha;
    logic                   consume;
    logic                   rescan;
    logic [1:0]             sel;
    logic [OFFSET_BITS-1:0] off_inc;
    logic [LINE_BITS-1:0]   line_inc;
    logic [LINE_BITS-1:0]   col_inc;
    logic                   a_v, b_v, e_v;
    token_t                 tok_a, tok_b, tok_e, tok_none;

    eoi      = in_eoi || (in_byte == CH_NUL);
    c        = eoi ? CH_NUL : in_byte;
    is_dig   = (c >= CH_0) && (c <= CH_9);
    is_alpha = ((c | CH_CASE_BIT) >= CH_A) && ((c | CH_CASE_BIT) <= CH_Z);
    sel      = (kw_sel == 2'd3) ? KW_TRUE : kw_sel;

    // saturating counter advance for a consumed byte
    off_inc = (byte_offset == OFF_MAX) ? byte_offset : byte_offset + 1'b1;
    if (c == CH_LF) begin
      line_inc = (line_count == LINE_MAX) ? line_count : line_count + 1'b1;
      col_inc  = LINE_ONE;
    end else begin
      line_inc = line_count;
      col_inc  = (column_count == LINE_MAX) ? column_count : column_count + 1'b1;
    end

    scan_state_next        = scan_state;
    kw_sel_next            = kw_sel;
    kw_idx_next            = kw_idx;
    byte_offset_next       = byte_offset;
    line_count_next        = line_count;
    column_count_next      = column_count;
    start_offset_hold_next = start_offset_hold;
    start_line_hold_next   = start_line_hold;
    start_column_hold_next = start_column_hold;
    consume  = 1'b0;
    rescan   = 1'b0;
    a_v      = 1'b0;
    b_v      = 1'b0;
    e_v      = 1'b0;
    tok_none = build_token(KIND_END, '0, '0, LINE_ONE, LINE_ONE, ERR_NONE);
    tok_a    = tok_none;
    tok_b    = tok_none;
    tok_e    = tok_none;

    unique case (scan_state)
      ST_ERROR: begin
      end
      ST_STR, ST_STR_ESC: begin
        if (eoi) begin
          a_v   = 1'b1;
          tok_a = build_token(KIND_ERROR, byte_offset, '0, start_line_hold,
                              start_column_hold, ERR_UNTERM);
          scan_state_next = ST_ERROR;
        end else if (scan_state == ST_STR_ESC) begin
          consume         = 1'b1;
          scan_state_next = ST_STR;
        end else if (c == CH_BSLASH) begin
          consume         = 1'b1;
          scan_state_next = ST_STR_ESC;
        end else if (c == CH_QUOTE) begin
          a_v   = 1'b1;
          tok_a = build_token(KIND_STRING, start_offset_hold, byte_offset - start_offset_hold,
                              start_line_hold, start_column_hold, ERR_NONE);
          consume         = 1'b1;
          scan_state_next = ST_IDLE;
        end else if (c < CH_SPACE) begin
          a_v   = 1'b1;
          tok_a = build_token(KIND_ERROR, byte_offset, '0, line_count, column_count, ERR_CTRL);
          scan_state_next = ST_ERROR;
        end else begin
          consume = 1'b1;
        end
      end
      ST_NEG: begin
        if (is_dig) begin
          consume         = 1'b1;
          scan_state_next = (c == CH_0) ? ST_ZERO : ST_INT;
        end else begin
          a_v   = 1'b1;
          tok_a = build_token(KIND_ERROR, byte_offset, '0, start_line_hold,
                              start_column_hold, ERR_NUMBER);
          scan_state_next = ST_ERROR;
        end
      end
      ST_ZERO, ST_INT, ST_FRAC: begin
        if (is_dig && scan_state != ST_ZERO) begin
          consume = 1'b1;
        end else if (c == CH_DOT && scan_state != ST_FRAC) begin
          consume         = 1'b1;
          scan_state_next = ST_DOT;
        end else if (c == CH_E || c == CH_UPPER_E) begin
          consume         = 1'b1;
          scan_state_next = ST_EXP;
        end else begin
          a_v   = 1'b1;
          tok_a = build_token(KIND_NUMBER, start_offset_hold, byte_offset - start_offset_hold,
                              start_line_hold, start_column_hold, ERR_NONE);
          scan_state_next = ST_IDLE;
          rescan          = 1'b1;
        end
      end
      ST_DOT: begin
        if (is_dig) begin
          consume         = 1'b1;
          scan_state_next = ST_FRAC;
        end else begin
          a_v   = 1'b1;
          tok_a = build_token(KIND_ERROR, byte_offset, '0, start_line_hold,
                              start_column_hold, ERR_FRAC);
          scan_state_next = ST_ERROR;
        end
      end
      ST_EXP, ST_EXP_SIGN: begin
        if (is_dig) begin
          consume         = 1'b1;
          scan_state_next = ST_EXP_DIG;
        end else if ((c == CH_PLUS || c == CH_MINUS) && scan_state == ST_EXP) begin
          consume         = 1'b1;
          scan_state_next = ST_EXP_SIGN;
        end else begin
          a_v   = 1'b1;
          tok_a = build_token(KIND_ERROR, byte_offset, '0, start_line_hold,
                              start_column_hold, ERR_EXP);
          scan_state_next = ST_ERROR;
        end
      end
      ST_EXP_DIG: begin
        if (is_dig) begin
          consume = 1'b1;
        end else begin
          a_v   = 1'b1;
          tok_a = build_token(KIND_NUMBER, start_offset_hold, byte_offset - start_offset_hold,
                              start_line_hold, start_column_hold, ERR_NONE);
          scan_state_next = ST_IDLE;
          rescan          = 1'b1;
        end
      end
      ST_KW: begin
        if (kw_idx < kw_len(sel)) begin
          if (!eoi && c == kw_char(sel, kw_idx)) begin
            consume     = 1'b1;
            kw_idx_next = kw_idx + 1'b1;
          end else begin
            a_v   = 1'b1;
            tok_a = build_token(KIND_ERROR, byte_offset, '0, start_line_hold,
                                start_column_hold, ERR_KEYWORD);
            scan_state_next = ST_ERROR;
          end
        end else if (is_alpha) begin
          a_v   = 1'b1;
          tok_a = build_token(KIND_ERROR, byte_offset, '0, start_line_hold,
                              start_column_hold, ERR_KEYWORD);
          scan_state_next = ST_ERROR;
        end else begin
          a_v   = 1'b1;
          tok_a = build_token(KIND_TRUE + {2'b00, sel}, start_offset_hold,
                              {{(OFFSET_BITS-3){1'b0}}, kw_len(sel)},
                              start_line_hold, start_column_hold, ERR_NONE);
          scan_state_next = ST_IDLE;
          rescan          = 1'b1;
        end
      end
      default: begin
        scan_state_next = ST_IDLE;
        rescan          = 1'b1;
      end
    endcase

    // idle scan; counters are untouched by the first phase whenever it rescans
    if (rescan && !eoi) begin
      case (c)
        CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
          consume = 1'b1;
        end
        CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET, CH_COLON, CH_COMMA: begin
          b_v = 1'b1;
          tok_b = build_token(KIND_COMMA, byte_offset, '0, line_count, column_count, ERR_NONE);
          case (c)
            CH_LBRACE:   tok_b.kind = KIND_LBRACE;
            CH_RBRACE:   tok_b.kind = KIND_RBRACE;
            CH_LBRACKET: tok_b.kind = KIND_LBRACKET;
            CH_RBRACKET: tok_b.kind = KIND_RBRACKET;
            CH_COLON:    tok_b.kind = KIND_COLON;
            default:     tok_b.kind = KIND_COMMA;
          endcase
          consume = 1'b1;
        end
        CH_QUOTE: begin
          // string text starts after the opening quote
          start_offset_hold_next = off_inc;
          start_line_hold_next   = line_count;
          start_column_hold_next = column_count;
          consume                = 1'b1;
          scan_state_next        = ST_STR;
        end
        CH_T, CH_F, CH_N: begin
          start_offset_hold_next = byte_offset;
          start_line_hold_next   = line_count;
          start_column_hold_next = column_count;
          consume                = 1'b1;
          kw_sel_next            = (c == CH_T) ? KW_TRUE : (c == CH_F) ? KW_FALSE : KW_NULL;
          kw_idx_next            = 3'd1;
          scan_state_next        = ST_KW;
        end
        default: begin
          if (c == CH_MINUS || is_dig) begin
            start_offset_hold_next = byte_offset;
            start_line_hold_next   = line_count;
            start_column_hold_next = column_count;
            consume                = 1'b1;
            scan_state_next        = (c == CH_MINUS) ? ST_NEG :
                                     (c == CH_0) ? ST_ZERO : ST_INT;
          end else begin
            b_v   = 1'b1;
            tok_b = build_token(KIND_ERROR, byte_offset, '0, line_count, column_count,
                                ERR_UNEXPECT);
            scan_state_next = ST_ERROR;
          end
        end
      endcase
    end

    if (consume) begin
      byte_offset_next  = off_inc;
      line_count_next   = line_inc;
      column_count_next = col_inc;
    end

    // end of document: end token, then back to the reset state
    if (eoi && (scan_state_next == ST_IDLE || scan_state_next == ST_ERROR)) begin
      e_v   = 1'b1;
      tok_e = build_token(KIND_END, byte_offset_next, '0, line_count_next, column_count_next,
                          ERR_NONE);
      scan_state_next        = ST_IDLE;
      kw_sel_next            = KW_TRUE;
      kw_idx_next            = 3'd0;
      byte_offset_next       = '0;
      line_count_next        = LINE_ONE;
      column_count_next      = LINE_ONE;
      start_offset_hold_next = '0;
      start_line_hold_next   = LINE_ONE;
      start_column_hold_next = LINE_ONE;
    end

    // pack the produced tokens in order; at most two per byte
    tok0   = a_v ? tok_a : (b_v ? tok_b : tok_e);
    tok1   = a_v ? (b_v ? tok_b : tok_e) : tok_e;
    push_n = 2'({1'b0, a_v} + {1'b0, b_v} + {1'b0, e_v});
    if (push_n == 2'd2) begin
      tok1.last = 1'b1;
    end else begin
      tok0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state        <= ST_IDLE;
      kw_sel            <= KW_TRUE;
      kw_idx            <= 3'd0;
      byte_offset       <= '0;
      line_count        <= LINE_ONE;
      column_count      <= LINE_ONE;
      start_offset_hold <= '0;
      start_line_hold   <= LINE_ONE;
      start_column_hold <= LINE_ONE;
    end else if (proc) begin
      scan_state        <= scan_state_next;
      kw_sel            <= kw_sel_next;
      kw_idx            <= kw_idx_next;
      byte_offset       <= byte_offset_next;
      line_count        <= line_count_next;
      column_count      <= column_count_next;
      start_offset_hold <= start_offset_hold_next;
      start_line_hold   <= start_line_hold_next;
      start_column_hold <= start_column_hold_next;
    end
  end

  // result queue
  assign pop = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (proc && push_n != 2'd0) begin
      fifo[wr_ptr] <= tok0;
    end
    if (proc && push_n == 2'd2) begin
      fifo[wr_ptr + 2'd1] <= tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= 2'd0;
      rd_ptr     <= 2'd0;
      fifo_count <= 3'd0;
    end else begin
      if (proc) begin
        wr_ptr <= wr_ptr + push_n;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      fifo_count <= fifo_count + (proc ? {1'b0, push_n} : 3'd0) - {2'b00, pop};
    end
  end

  assign m_tvalid = (fifo_count != 3'd0);
  assign m_tuser  = fifo[rd_ptr].kind;
  assign m_tlast  = fifo[rd_ptr].last;
  assign m_tdata  = {5'b00000, fifo[rd_ptr].err, fifo[rd_ptr].column, fifo[rd_ptr].line,
                     fifo[rd_ptr].length, fifo[rd_ptr].offset};

`ifndef SYNTHESIS
  // queue never overfills
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= 3'd4)
    else $error("result queue overflow");

  // an end of document always returns the scanner to its reset position
  a_eoi_resets: assert property (@(posedge clk) disable iff (rst)
    (proc && (in_eoi || in_byte == CH_NUL)) |=>
      (scan_state == ST_IDLE && byte_offset == '0 && line_count == LINE_ONE))
    else $error("scanner not reset after end of document");

  // the end token closes its byte's run
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_END) |-> m_tlast)
    else $error("end token not last of run");

  // punctuation carries no text
  a_punct_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser <= KIND_COMMA) |-> (m_tdata[2*OFFSET_BITS-1:OFFSET_BITS] == '0))
    else $error("punctuation token with nonzero length");
`endif

endmodule

`default_nettype wire
